### hw/rtl/dcfw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfw_pkg
// shared types and constants of the drive command sequencer with watchdog
// ----------------------------------------------------------------------------
package dcfw_pkg;

  // counter width of the poll and inactivity counters
  localparam int unsigned COUNT_BITS   = 16;
  localparam int unsigned TIMER_BITS   = 16;
  localparam int unsigned CMP_BITS     = (COUNT_BITS > TIMER_BITS) ? COUNT_BITS : TIMER_BITS;

  localparam int unsigned SPEED_BITS   = 7;
  localparam int unsigned MOTOR_BITS   = 8;
  localparam int unsigned DIR_BITS     = 3;
  localparam int unsigned LEVEL_BITS   = 2;

  // stream word widths
  localparam int unsigned IN_DATA_BITS  = 8;
  localparam int unsigned OUT_DATA_BITS = 24;

  // configuration port
  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [CFG_ADDR_BITS-1:0] REG_POLL_PERIOD      = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_STRAIGHT_TIMEOUT = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_TURN_TIMEOUT     = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LOW_SPEED        = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MID_SPEED        = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_HIGH_SPEED       = 3'd5;

  localparam logic [TIMER_BITS-1:0] POLL_PERIOD_RST      = 16'd50;
  localparam logic [TIMER_BITS-1:0] STRAIGHT_TIMEOUT_RST = 16'd50;
  localparam logic [TIMER_BITS-1:0] TURN_TIMEOUT_RST     = 16'd25;
  localparam logic [SPEED_BITS-1:0] LOW_SPEED_RST        = 7'd33;
  localparam logic [SPEED_BITS-1:0] MID_SPEED_RST        = 7'd66;
  localparam logic [SPEED_BITS-1:0] HIGH_SPEED_RST       = 7'd100;

  // direction codes
  localparam logic [DIR_BITS-1:0] DIR_STOP     = 3'd0;
  localparam logic [DIR_BITS-1:0] DIR_FORWARD  = 3'd1;
  localparam logic [DIR_BITS-1:0] DIR_BACKWARD = 3'd2;
  localparam logic [DIR_BITS-1:0] DIR_LEFT     = 3'd3;
  localparam logic [DIR_BITS-1:0] DIR_RIGHT    = 3'd4;

  // intensity codes
  localparam logic [LEVEL_BITS-1:0] LVL_LOW  = 2'd0;
  localparam logic [LEVEL_BITS-1:0] LVL_MID  = 2'd1;
  localparam logic [LEVEL_BITS-1:0] LVL_HIGH = 2'd2;

  typedef enum logic [1:0] {
    PH_INIT    = 2'd0,
    PH_IDLE    = 2'd1,
    PH_PROCESS = 2'd2,
    PH_ERROR   = 2'd3
  } phase_t;

endpackage

### hw/rtl/drive_command_fsm_with_watchdog.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_command_fsm_with_watchdog
// drive command sequencer with per-direction motion watchdog
// ----------------------------------------------------------------------------
// each input word is one tick carrying a possibly new drive command; each
// tick yields exactly one output word with motor speeds, pulses and lamps.
// channels: in_* slave stream (tick words), out_* master stream (results),
// cfg_* plain write port for the six setup registers (write only when idle).
// path: an accepted word lands in the input register, its result is built by
// one pass of logic and lands in the output register, visible on out_* from
// then on.
// throughput: one word per cycle unless stalled, set by the single-pass sequencer step;
// the input register refills in the same cycle the output word is taken.
// reset (rst_n low, synchronous): both stream registers empty, sequencer in
// init, counters zero, watchdog disarmed, lamps off, setup registers back
// to their defaults (poll 50, straight 50, turn 25, speeds 33/66/100).
// receiver stall: the output word holds; the input register keeps its word
// and in_tready drops once both registers are full, so nothing is lost.
// ----------------------------------------------------------------------------
module drive_command_fsm_with_watchdog (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tick input: cmd_ready[0], cmd_ok[1], direction[4:2], intensity[6:5], pad[7]
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dcfw_pkg::IN_DATA_BITS-1:0]    in_tdata,
  // result: drive_write[0], left_speed[8:1], right_speed[16:9],
  // emergency_stop[17], poll_request[18], link_start[19], timeout_stop[20],
  // busy_lamp[21], halt_lamp[22], move_lamp[23]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [dcfw_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  // setup register writes
  input  logic                                 cfg_we,
  input  logic [dcfw_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [dcfw_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import dcfw_pkg::*;

  // setup registers
  logic [TIMER_BITS-1:0] poll_period_r, straight_timeout_r, turn_timeout_r;
  logic [SPEED_BITS-1:0] low_speed_r, mid_speed_r, high_speed_r;

  // stream registers
  logic                     s1_valid_r;
  logic [IN_DATA_BITS-1:0]  s1_data_r;
  logic                     out_valid_r;
  logic [OUT_DATA_BITS-1:0] out_data_r;
  logic                     s1_adv;

  // sequencer state
  phase_t                phase_r, phase_nxt;
  logic [DIR_BITS-1:0]   held_dir_r, held_dir_nxt;
  logic [LEVEL_BITS-1:0] held_lvl_r, held_lvl_nxt;
  logic [COUNT_BITS-1:0] poll_cnt_r, poll_cnt_nxt;
  logic [COUNT_BITS-1:0] idle_cnt_r, idle_cnt_nxt;
  logic                  wd_armed_r, wd_armed_nxt;
  logic [DIR_BITS-1:0]   motion_r, motion_nxt;
  logic                  busy_r, busy_nxt;
  logic                  halt_r, halt_nxt;
  logic                  move_r, move_nxt;

  // unpacked tick word
  logic                  cmd_ready, cmd_ok;
  logic [DIR_BITS-1:0]   cmd_dir;
  logic [LEVEL_BITS-1:0] cmd_lvl;

  // result fields of this tick
  logic                  drive_write, estop, poll_req, link_start, tstop;
  logic [MOTOR_BITS-1:0] left_speed, right_speed;

  // helpers
  logic [TIMER_BITS-1:0] wd_limit;
  logic [SPEED_BITS-1:0] mag;
  logic [MOTOR_BITS-1:0] pos_speed, neg_speed;
  logic [COUNT_BITS-1:0] idle_inc, poll_inc;

  assign cmd_ready = s1_data_r[0];
  assign cmd_ok    = s1_data_r[1];
  assign cmd_dir   = s1_data_r[4:2];
  assign cmd_lvl   = s1_data_r[6:5];

  // handshake: the input register moves on whenever the output slot frees
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // setup registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_period_r      <= POLL_PERIOD_RST;
      straight_timeout_r <= STRAIGHT_TIMEOUT_RST;
      turn_timeout_r     <= TURN_TIMEOUT_RST;
      low_speed_r        <= LOW_SPEED_RST;
      mid_speed_r        <= MID_SPEED_RST;
      high_speed_r       <= HIGH_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_POLL_PERIOD:      poll_period_r      <= cfg_wdata[TIMER_BITS-1:0];
        REG_STRAIGHT_TIMEOUT: straight_timeout_r <= cfg_wdata[TIMER_BITS-1:0];
        REG_TURN_TIMEOUT:     turn_timeout_r     <= cfg_wdata[TIMER_BITS-1:0];
        REG_LOW_SPEED:        low_speed_r        <= cfg_wdata[SPEED_BITS-1:0];
        REG_MID_SPEED:        mid_speed_r        <= cfg_wdata[SPEED_BITS-1:0];
        REG_HIGH_SPEED:       high_speed_r       <= cfg_wdata[SPEED_BITS-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {move_nxt, halt_nxt, busy_nxt, tstop, link_start, poll_req,
                     estop, right_speed, left_speed, drive_write};
    end
  end

  // sequencer state, only steps when a tick moves into the output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_INIT;
      held_dir_r <= DIR_STOP;
      held_lvl_r <= LVL_LOW;
      poll_cnt_r <= '0;
      idle_cnt_r <= '0;
      wd_armed_r <= 1'b0;
      motion_r   <= DIR_STOP;
      busy_r     <= 1'b0;
      halt_r     <= 1'b0;
      move_r     <= 1'b0;
    end else if (s1_adv) begin
      phase_r    <= phase_nxt;
      held_dir_r <= held_dir_nxt;
      held_lvl_r <= held_lvl_nxt;
      poll_cnt_r <= poll_cnt_nxt;
      idle_cnt_r <= idle_cnt_nxt;
      wd_armed_r <= wd_armed_nxt;
      motion_r   <= motion_nxt;
      busy_r     <= busy_nxt;
      halt_r     <= halt_nxt;
      move_r     <= move_nxt;
    end
  end

  // watchdog limit picked by the motion in progress
  always_comb begin
    if (motion_r == DIR_FORWARD || motion_r == DIR_BACKWARD) begin
      wd_limit = straight_timeout_r;
    end else if (motion_r == DIR_LEFT || motion_r == DIR_RIGHT) begin
      wd_limit = turn_timeout_r;
    end else begin
      wd_limit = '0;
    end
  end

  // speed magnitude from the held intensity; a held stop or unknown intensity gives zero
  always_comb begin
    if (held_dir_r == DIR_STOP) begin
      mag = '0;
    end else begin
      unique case (held_lvl_r)
        LVL_LOW:  mag = low_speed_r;
        LVL_MID:  mag = mid_speed_r;
        LVL_HIGH: mag = high_speed_r;
        default:  mag = '0;
      endcase
    end
  end

  assign pos_speed = {1'b0, mag};
  assign neg_speed = MOTOR_BITS'(8'd0 - pos_speed);
  assign idle_inc  = COUNT_BITS'(idle_cnt_r + 1'b1);
  assign poll_inc  = COUNT_BITS'(poll_cnt_r + 1'b1);

  // next state and result of one tick
  always_comb begin
    phase_nxt    = phase_r;
    held_dir_nxt = held_dir_r;
    held_lvl_nxt = held_lvl_r;
    poll_cnt_nxt = poll_cnt_r;
    idle_cnt_nxt = idle_cnt_r;
    wd_armed_nxt = wd_armed_r;
    motion_nxt   = motion_r;
    busy_nxt     = busy_r;
    halt_nxt     = halt_r;
    move_nxt     = move_r;
    drive_write  = 1'b0;
    estop        = 1'b0;
    poll_req     = 1'b0;
    link_start   = 1'b0;
    tstop        = 1'b0;
    left_speed   = '0;
    right_speed  = '0;

    unique case (phase_r)
      PH_INIT: begin
        link_start = 1'b1;
        phase_nxt  = PH_IDLE;
      end

      PH_IDLE: begin
        if (cmd_ready) begin
          // take the command, process or error on the next tick
          busy_nxt     = 1'b1;
          held_dir_nxt = cmd_dir;
          held_lvl_nxt = cmd_lvl;
          phase_nxt    = cmd_ok ? PH_PROCESS : PH_ERROR;
          poll_cnt_nxt = '0;
          idle_cnt_nxt = '0;
        end else begin
          // inactivity watchdog, zero limit means off
          if (wd_armed_r && wd_limit != '0) begin
            idle_cnt_nxt = idle_inc;
            if (CMP_BITS'(idle_inc) >= CMP_BITS'(wd_limit)) begin
              drive_write  = 1'b1;
              tstop        = 1'b1;
              wd_armed_nxt = 1'b0;
              idle_cnt_nxt = '0;
            end
          end
          poll_cnt_nxt = poll_inc;
          if (CMP_BITS'(poll_inc) >= CMP_BITS'(poll_period_r)) begin
            poll_req     = 1'b1;
            poll_cnt_nxt = '0;
          end
        end
      end

      PH_PROCESS: begin
        halt_nxt     = (held_dir_r == DIR_STOP);
        move_nxt     = (held_dir_r != DIR_STOP);
        idle_cnt_nxt = '0;
        if (held_dir_r >= DIR_FORWARD && held_dir_r <= DIR_RIGHT) begin
          drive_write  = 1'b1;
          left_speed   = (held_dir_r == DIR_FORWARD || held_dir_r == DIR_LEFT)
                         ? pos_speed : neg_speed;
          right_speed  = (held_dir_r == DIR_FORWARD || held_dir_r == DIR_RIGHT)
                         ? pos_speed : neg_speed;
          wd_armed_nxt = 1'b1;
          motion_nxt   = held_dir_r;
        end else begin
          // stop writes zero speeds, unknown direction writes nothing
          drive_write  = (held_dir_r == DIR_STOP);
          wd_armed_nxt = 1'b0;
          motion_nxt   = DIR_STOP;
        end
        busy_nxt     = 1'b0;
        poll_cnt_nxt = '0;
        phase_nxt    = PH_IDLE;
      end

      PH_ERROR: begin
        busy_nxt     = 1'b0;
        estop        = 1'b1;
        poll_cnt_nxt = '0;
        wd_armed_nxt = 1'b0;
        motion_nxt   = DIR_STOP;
        idle_cnt_nxt = '0;
        phase_nxt    = PH_IDLE;
      end

      default: phase_nxt = PH_IDLE;
    endcase
  end

endmodule

### hw/rtl/dcfw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfw_checker
// port-level checks of the drive command sequencer
// ----------------------------------------------------------------------------
module dcfw_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [dcfw_pkg::OUT_DATA_BITS-1:0] out_tdata
);
  import dcfw_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed under stall");

  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // speeds are zero unless a drive write is flagged
  a_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[16:1] == 16'd0)
    else $error("speed without drive write");

  // emergency stop never writes motors and clears busy
  a_estop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> !out_tdata[0] && !out_tdata[21])
    else $error("emergency stop with drive write or busy");

  // halt and move lamps are never on together
  a_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[22] && out_tdata[23]))
    else $error("halt and move lamps both on");

endmodule

bind drive_command_fsm_with_watchdog dcfw_checker u_dcfw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
